### sv/ctl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctl_pkg: shared types and defaults for the closed tour length block
// Holds the sequencer state type and the default parameter values.
// ----------------------------------------------------------------------------
package ctl_pkg;

  localparam int DEF_COORD_WIDTH = 16;
  localparam int DEF_FRAC_BITS   = 16;
  localparam int DEF_SUM_WIDTH   = 56;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQX,
    ST_SQY,
    ST_ROOT,
    ST_ACC,
    ST_OUT
  } state_t;

endpackage

### sv/closed_tour_length.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closed_tour_length: perimeter of a closed tour of points
// Sums truncated Euclidean leg lengths in unsigned fixed point and emits the
// saturated total when the point flagged as last closes the tour.
// ----------------------------------------------------------------------------
// Each point request is taken when the block is idle. The first point of a
// tour is stored. Every later point computes one leg: the coordinate
// differences, squaring on the shared multiplier, a restoring square root
// that retires one root bit per cycle into the QW-bit root, where
// QW = ceil((2*COORD_WIDTH + 1 + 2*FRAC_BITS) / 2) is 33 at the defaults,
// and the saturating add. A last point that is not the first runs a second
// leg back to the first point, then loads the output register once it is
// free. The result sits in its own register, so the next tour starts while
// the total waits to be taken.
module closed_tour_length
  import ctl_pkg::*;
#(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  parameter int FRAC_BITS   = DEF_FRAC_BITS,
  parameter int SUM_WIDTH   = DEF_SUM_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pt_valid,
  output logic                          pt_ready,
  input  logic signed [COORD_WIDTH-1:0] x_coord,
  input  logic signed [COORD_WIDTH-1:0] y_coord,
  input  logic                          last_point,
  output logic                          len_valid,
  input  logic                          len_ready,
  output logic        [SUM_WIDTH-1:0]   tour_length
);

  localparam int SW   = 2 * COORD_WIDTH + 1;
  localparam int QW   = (SW + 2 * FRAC_BITS + 1) / 2;
  localparam int RW   = 2 * QW;
  localparam int RMW  = QW + 3;
  localparam int CNTW = $clog2(QW + 1);
  localparam int AW   = ((QW > SUM_WIDTH) ? QW : SUM_WIDTH) + 1;
  localparam logic [SUM_WIDTH-1:0] SUM_MAX = {SUM_WIDTH{1'b1}};

  state_t state, state_next;

  logic                          started;
  logic                          leg_close;
  logic                          last_flag;
  logic signed [COORD_WIDTH-1:0] cur_x, cur_y, first_x, first_y, prev_x, prev_y;
  logic        [COORD_WIDTH-1:0] dx, dy;
  logic        [SW-1:0]          sq_sum;
  logic        [RW-1:0]          rad;
  logic        [RMW-1:0]         rem;
  logic        [QW-1:0]          root;
  logic        [CNTW-1:0]        cnt;
  logic        [SUM_WIDTH-1:0]   length_sum;

  logic                          accept;
  logic                          load_out;
  logic signed [COORD_WIDTH:0]   diff_x, diff_y;
  logic        [COORD_WIDTH-1:0] mul_op;
  logic        [2*COORD_WIDTH-1:0] prod;
  logic        [SW-1:0]          sq_sum_next;
  logic        [RMW-1:0]         rem_sh, trial;
  logic        [AW-1:0]          sum_ext;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (pt_valid) begin
          if (started || last_point) state_next = ST_DIFF;
        end
      end
      ST_DIFF: state_next = ST_SQX;
      ST_SQX:  state_next = ST_SQY;
      ST_SQY:  state_next = ST_ROOT;
      ST_ROOT: begin
        if (cnt == CNTW'(1)) state_next = ST_ACC;
      end
      ST_ACC: begin
        if (!last_flag) state_next = ST_IDLE;
        else if (!leg_close) state_next = ST_DIFF;
        else state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!len_valid || len_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    pt_ready = 1'b0;
    load_out = 1'b0;
    case (state)
      ST_IDLE: pt_ready = 1'b1;
      ST_OUT:  load_out = !len_valid || len_ready;
      default: begin
        pt_ready = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  assign accept = pt_valid && pt_ready;

  // The open legs run from the previous point, the closing leg from the first.
  assign diff_x = {cur_x[COORD_WIDTH-1], cur_x} -
                  (leg_close ? {first_x[COORD_WIDTH-1], first_x}
                             : {prev_x[COORD_WIDTH-1], prev_x});
  assign diff_y = {cur_y[COORD_WIDTH-1], cur_y} -
                  (leg_close ? {first_y[COORD_WIDTH-1], first_y}
                             : {prev_y[COORD_WIDTH-1], prev_y});

  assign mul_op      = (state == ST_SQX) ? dx : dy;
  assign prod        = mul_op * mul_op;
  assign sq_sum_next = sq_sum + SW'(prod);

  assign rem_sh  = {rem[RMW-3:0], rad[RW-1 -: 2]};
  assign trial   = RMW'({root, 2'b01});
  assign sum_ext = AW'(length_sum) + AW'(root);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      started   <= 1'b0;
      leg_close <= 1'b0;
      len_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        started   <= 1'b1;
        leg_close <= !started;
      end
      if (state == ST_ACC && last_flag && !leg_close) leg_close <= 1'b1;
      if (load_out) begin
        len_valid <= 1'b1;
        started   <= 1'b0;
      end else if (len_ready) begin
        len_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_x     <= x_coord;
      cur_y     <= y_coord;
      last_flag <= last_point;
      if (!started) begin
        first_x    <= x_coord;
        first_y    <= y_coord;
        prev_x     <= x_coord;
        prev_y     <= y_coord;
        length_sum <= '0;
      end
    end
    case (state)
      ST_DIFF: begin
        dx     <= diff_x[COORD_WIDTH] ? COORD_WIDTH'(-diff_x) : diff_x[COORD_WIDTH-1:0];
        dy     <= diff_y[COORD_WIDTH] ? COORD_WIDTH'(-diff_y) : diff_y[COORD_WIDTH-1:0];
        prev_x <= cur_x;
        prev_y <= cur_y;
      end
      ST_SQX: sq_sum <= SW'(prod);
      ST_SQY: begin
        rad  <= RW'(sq_sum_next) << (2 * FRAC_BITS);
        rem  <= '0;
        root <= '0;
        cnt  <= CNTW'(QW);
      end
      ST_ROOT: begin
        // One root bit per cycle, restoring form.
        rad <= {rad[RW-3:0], 2'b00};
        cnt <= cnt - CNTW'(1);
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[QW-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[QW-2:0], 1'b0};
        end
      end
      ST_ACC: begin
        if (sum_ext > AW'(SUM_MAX)) length_sum <= SUM_MAX;
        else length_sum <= sum_ext[SUM_WIDTH-1:0];
      end
      default: begin
      end
    endcase
    if (load_out) tour_length <= length_sum;
  end

endmodule
